FILE: design/desp_pkg.sv
// Shared types and constants for the display escape-sequence parser.
// Has no dependencies. Used by the sequencer, the result stage and the top level.
package desp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned KIND_W = 2;

	localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1B;

	// Command bytes that follow an escape.
	localparam logic [BYTE_W-1:0] CMD_CURSOR = 8'd1;
	localparam logic [BYTE_W-1:0] CMD_SET_HL = 8'd2;
	localparam logic [BYTE_W-1:0] CMD_CLR_HL = 8'd3;

	// Kinds of display command on the result channel.
	localparam logic [KIND_W-1:0] KIND_PRINT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CURSOR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SET_HL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLR_HL = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] cmd_kind;
		logic [BYTE_W-1:0] char_code;
		logic [BYTE_W-1:0] row;
		logic [BYTE_W-1:0] column;
		logic [BYTE_W-1:0] width;
	} result_t;

	// Outcome of decoding one byte against the sequence state.
	typedef struct packed {
		logic    has_result;
		result_t result;
	} decode_t;

endpackage

FILE: design/desp_seq.sv
// Sequence tracker: phase, command byte and stored arguments, plus the decode
// of one byte into at most one display command. Depends on desp_pkg.
module desp_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [desp_pkg::BYTE_W-1:0]  byte_in,
	input  logic                         step,
	output desp_pkg::decode_t            dec
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_ESC  = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_ARG1 = 3'd3;
	localparam logic [2:0] PH_ARG2 = 3'd4;

	logic [2:0]                  phase_q, phase_nxt;
	logic [desp_pkg::BYTE_W-1:0] cmd_q, arg1_q, arg2_q;
	logic                        wr_cmd, wr_arg1, wr_arg2;
	logic                        is_cursor, is_hl;

	assign is_cursor = (cmd_q == desp_pkg::CMD_CURSOR);
	assign is_hl     = (cmd_q == desp_pkg::CMD_SET_HL) || (cmd_q == desp_pkg::CMD_CLR_HL);

	always_comb begin
		phase_nxt = PH_IDLE;
		wr_cmd    = 1'b0;
		wr_arg1   = 1'b0;
		wr_arg2   = 1'b0;
		dec       = '0;
		// Unless an arm says otherwise, the byte is printed and the sequence closes.
		dec.has_result         = 1'b1;
		dec.result.cmd_kind    = desp_pkg::KIND_PRINT;
		dec.result.char_code   = byte_in;
		if (byte_in == desp_pkg::ESC_BYTE) begin
			// An escape restarts the sequence wherever we are.
			phase_nxt      = PH_ESC;
			dec            = '0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_ESC: begin
					wr_cmd    = 1'b1;
					phase_nxt = PH_CMD;
					dec       = '0;
				end
				PH_CMD: begin
					if (is_cursor || is_hl) begin
						wr_arg1   = 1'b1;
						phase_nxt = PH_ARG1;
						dec       = '0;
					end
				end
				PH_ARG1: begin
					if (is_cursor) begin
						dec.result.cmd_kind  = desp_pkg::KIND_CURSOR;
						dec.result.char_code = '0;
						dec.result.row       = arg1_q;
						dec.result.column    = byte_in;
					end else if (is_hl) begin
						wr_arg2   = 1'b1;
						phase_nxt = PH_ARG2;
						dec       = '0;
					end
				end
				PH_ARG2: begin
					if (is_hl) begin
						dec.result.cmd_kind  = (cmd_q == desp_pkg::CMD_SET_HL) ?
							desp_pkg::KIND_SET_HL : desp_pkg::KIND_CLR_HL;
						dec.result.char_code = '0;
						dec.result.row       = arg1_q;
						dec.result.column    = arg2_q;
						dec.result.width     = byte_in;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (step) begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_cmd) begin
			cmd_q <= byte_in;
		end
		if (step && wr_arg1) begin
			arg1_q <= byte_in;
		end
		if (step && wr_arg2) begin
			arg2_q <= byte_in;
		end
	end

endmodule

FILE: design/desp_out_stage.sv
// Result register of the parser: holds one finished display command until the
// receiver takes it. Depends on desp_pkg.
module desp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  desp_pkg::result_t load_data,
	input  logic              take,
	output logic              free,
	output logic              valid_s2,
	output desp_pkg::result_t data_s2
);

	// The slot can be refilled in the same cycle its item leaves.
	assign free = !valid_s2 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2 <= load_data;
		end
	end

endmodule

FILE: design/display_escape_sequence_parser.sv
// Top level of the display escape-sequence parser: input register, sequence
// tracker and result register. Depends on desp_pkg, desp_seq, desp_out_stage.
//
// Usage: each input item is one byte bound for a character display, offered on
// in_byte with in_valid/in_ready. Ordinary bytes come out as print-character
// commands. The escape byte 0x1B opens a sequence (also inside another one);
// the following command byte selects set cursor (row, column), set highlight
// or clear highlight (row, column, width). An unknown command makes the next
// byte print. Escape, command and argument bytes that do not finish a command
// give no result item.
//
// Timing: a byte is registered at acceptance, decoded against the sequence
// state in the next cycle and written into the result register, from which
// the result item is offered on out_valid. One byte is taken every cycle
// unless the registered byte waits for a full result register.
// When the receiver holds out_ready low, the result register keeps its item,
// the registered byte waits if it would produce a result, and in_ready drops
// once both stages are full. Bytes that produce no result keep flowing.
// Reset clears the sequence phase to no open sequence and empties both stages.
module display_escape_sequence_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [desp_pkg::BYTE_W-1:0]   in_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [desp_pkg::KIND_W-1:0]   cmd_kind,
	output logic [desp_pkg::BYTE_W-1:0]   char_code,
	output logic [desp_pkg::BYTE_W-1:0]   row,
	output logic [desp_pkg::BYTE_W-1:0]   column,
	output logic [desp_pkg::BYTE_W-1:0]   width
);

	logic                        valid_s1;
	logic [desp_pkg::BYTE_W-1:0] byte_s1;
	logic                        advance;
	logic                        out_free;
	desp_pkg::decode_t           dec;
	desp_pkg::result_t           res_s2;

	// The registered byte moves on when it yields nothing or the result slot is free.
	assign advance  = valid_s1 && (!dec.has_result || out_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	desp_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_s1),
		.step    (advance),
		.dec     (dec)
	);

	desp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && dec.has_result),
		.load_data (dec.result),
		.take      (out_ready),
		.free      (out_free),
		.valid_s2  (out_valid),
		.data_s2   (res_s2)
	);

	assign cmd_kind  = res_s2.cmd_kind;
	assign char_code = res_s2.char_code;
	assign row       = res_s2.row;
	assign column    = res_s2.column;
	assign width     = res_s2.width;

endmodule

FILE: dv/display_command_checker.sv
// Checker for the display escape-sequence parser: tracks the byte stream on the input channel,
// predicts the display commands and compares them with the result channel.
// Depends on desp_pkg for the escape byte, command bytes, command kinds and result_t.
module display_command_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [desp_pkg::BYTE_W-1:0]   in_byte,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [desp_pkg::KIND_W-1:0]   cmd_kind,
	input  logic [desp_pkg::BYTE_W-1:0]   char_code,
	input  logic [desp_pkg::BYTE_W-1:0]   row,
	input  logic [desp_pkg::BYTE_W-1:0]   column,
	input  logic [desp_pkg::BYTE_W-1:0]   width,
	output int unsigned                   mismatch_count,
	output int unsigned                   expected_count
);

	localparam logic [2:0] SEQ_NONE        = 3'd0;
	localparam logic [2:0] SEQ_ESC_SEEN    = 3'd1;
	localparam logic [2:0] SEQ_CMD_HELD    = 3'd2;
	localparam logic [2:0] SEQ_ROW_HELD    = 3'd3;
	localparam logic [2:0] SEQ_COLUMN_HELD = 3'd4;

	logic [2:0]                   seq_phase = SEQ_NONE;
	logic [desp_pkg::BYTE_W-1:0]  held_cmd = '0;
	logic [desp_pkg::BYTE_W-1:0]  held_row = '0;
	logic [desp_pkg::BYTE_W-1:0]  held_column = '0;
	desp_pkg::result_t            pending_cmds[$];
	int unsigned                  fail_total = 0;

	initial expected_count = 0;
	assign mismatch_count = fail_total;

	task automatic report_mismatch(input string msg);
		$display("%0t: display command mismatch: %s", $time, msg);
		fail_total++;
	endtask

	// Advances the sequence state by one byte and queues the display command it
	// finishes, if any.
	task automatic track_display_byte(input logic [desp_pkg::BYTE_W-1:0] b);
		desp_pkg::result_t cmd;
		logic              has_cmd;
		cmd = '0;
		has_cmd = 1'b0;
		if (b == desp_pkg::ESC_BYTE) begin
			seq_phase = SEQ_ESC_SEEN;
		end else begin
			case (seq_phase)
				SEQ_NONE: begin
					has_cmd = 1'b1;
					cmd.cmd_kind = desp_pkg::KIND_PRINT;
					cmd.char_code = b;
				end
				SEQ_ESC_SEEN: begin
					held_cmd = b;
					seq_phase = SEQ_CMD_HELD;
				end
				SEQ_CMD_HELD: begin
					if (held_cmd == desp_pkg::CMD_CURSOR || held_cmd == desp_pkg::CMD_SET_HL ||
							held_cmd == desp_pkg::CMD_CLR_HL) begin
						held_row = b;
						seq_phase = SEQ_ROW_HELD;
					end else begin
						has_cmd = 1'b1;
						cmd.cmd_kind = desp_pkg::KIND_PRINT;
						cmd.char_code = b;
						seq_phase = SEQ_NONE;
					end
				end
				SEQ_ROW_HELD: begin
					if (held_cmd == desp_pkg::CMD_CURSOR) begin
						has_cmd = 1'b1;
						cmd.cmd_kind = desp_pkg::KIND_CURSOR;
						cmd.row = held_row;
						cmd.column = b;
						seq_phase = SEQ_NONE;
					end else begin
						held_column = b;
						seq_phase = SEQ_COLUMN_HELD;
					end
				end
				default: begin
					has_cmd = 1'b1;
					cmd.cmd_kind = (held_cmd == desp_pkg::CMD_SET_HL) ?
						desp_pkg::KIND_SET_HL : desp_pkg::KIND_CLR_HL;
					cmd.row = held_row;
					cmd.column = held_column;
					cmd.width = b;
					seq_phase = SEQ_NONE;
				end
			endcase
		end
		if (has_cmd)
			pending_cmds.push_back(cmd);
	endtask

	task automatic check_display_cmd();
		desp_pkg::result_t want;
		if (pending_cmds.size() == 0) begin
			report_mismatch($sformatf("result kind %0d with none pending", cmd_kind));
		end else begin
			want = pending_cmds.pop_front();
			if (cmd_kind !== want.cmd_kind)
				report_mismatch($sformatf("cmd_kind %0h, want %0h", cmd_kind, want.cmd_kind));
			if (char_code !== want.char_code)
				report_mismatch($sformatf("char_code %0h, want %0h", char_code, want.char_code));
			if (row !== want.row)
				report_mismatch($sformatf("row %0h, want %0h", row, want.row));
			if (column !== want.column)
				report_mismatch($sformatf("column %0h, want %0h", column, want.column));
			if (width !== want.width)
				report_mismatch($sformatf("width %0h, want %0h", width, want.width));
		end
	endtask

	// Results are checked before the new byte is tracked; a byte cannot produce
	// a result in the cycle it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_phase = SEQ_NONE;
			pending_cmds.delete();
			expected_count <= 0;
		end else begin
			if (out_valid && out_ready)
				check_display_cmd();
			if (in_valid && in_ready)
				track_display_byte(in_byte);
			expected_count <= pending_cmds.size();
		end
	end

endmodule

FILE: dv/display_escape_sequence_parser_tb.sv
// Testbench top for the display escape-sequence parser: clock, reset, byte stream
// stimulus and receiver stalls. Depends on desp_pkg, the parser and display_command_checker.
module display_escape_sequence_parser_tb;

	typedef logic [desp_pkg::BYTE_W-1:0] byte_t;

	// Generous bound on the run, far beyond what a correct run needs.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Random bytes sent in each of the three stall phases.
	localparam int unsigned PHASE_BYTES = 650;

	localparam byte_t KNOWN_CMDS [3] = '{desp_pkg::CMD_CURSOR, desp_pkg::CMD_SET_HL,
		desp_pkg::CMD_CLR_HL};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	byte_t                          in_byte = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [desp_pkg::KIND_W-1:0]    cmd_kind;
	byte_t                          char_code;
	byte_t                          row;
	byte_t                          column;
	byte_t                          width;

	int unsigned          mismatch_count;
	int unsigned          expected_count;
	int unsigned          cycle_count = 0;
	// Chance in percent that the sender or the receiver sits out a cycle.
	int unsigned          send_idle_pct = 0;
	int unsigned          recv_idle_pct = 0;
	int unsigned          bytes_sent = 0;

	display_escape_sequence_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd_kind  (cmd_kind),
		.char_code (char_code),
		.row       (row),
		.column    (column),
		.width     (width)
	);

	display_command_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cmd_kind       (cmd_kind),
		.char_code      (char_code),
		.row            (row),
		.column         (column),
		.width          (width),
		.mismatch_count (mismatch_count),
		.expected_count (expected_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// The receiver stalls cycle by cycle at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Offers one byte and returns at the edge where it is accepted. Idle cycles go
	// in front of the byte, so valid only drops between items and never while one
	// is on offer. Back-to-back items keep valid high with a single assignment.
	task automatic send_byte(input byte_t b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		bytes_sent++;
	endtask

	// Stops the sender until every predicted command has come out. The first edge
	// lets the checker count a byte accepted at the current edge.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_count != 0);
	endtask

	// Any byte but the escape, so it cannot reopen a sequence.
	function automatic byte_t plain_byte();
		byte_t b;
		do
			b = byte_t'($urandom_range(255));
		while (b == desp_pkg::ESC_BYTE);
		return b;
	endfunction

	// A command byte that selects none of the known commands.
	function automatic byte_t unknown_cmd_byte();
		byte_t b;
		do
			b = plain_byte();
		while (b == desp_pkg::CMD_CURSOR || b == desp_pkg::CMD_SET_HL ||
			b == desp_pkg::CMD_CLR_HL);
		return b;
	endfunction

	// Sends a random stream made mostly of complete sequences with random
	// arguments, plus plain text, unknown commands, sequences cut short by a new
	// escape and raw noise in which the escape byte is common.
	task automatic send_random_stream(input int unsigned count);
		int unsigned       stop_at;
		int unsigned       pick;
		int unsigned       n_args;
		byte_t             cmd;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				// Complete cursor or highlight sequence.
				cmd = KNOWN_CMDS[2'($urandom_range(2))];
				n_args = (cmd == desp_pkg::CMD_CURSOR) ? 2 : 3;
				send_byte(desp_pkg::ESC_BYTE);
				send_byte(cmd);
				repeat (n_args) send_byte(plain_byte());
			end else if (pick < 62) begin
				// Unknown command: the byte after it prints.
				send_byte(desp_pkg::ESC_BYTE);
				send_byte(unknown_cmd_byte());
				send_byte(plain_byte());
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 4)) send_byte(plain_byte());
			end else if (pick < 90) begin
				// Sequence abandoned part way; the next escape restarts parsing.
				cmd = KNOWN_CMDS[2'($urandom_range(2))];
				send_byte(desp_pkg::ESC_BYTE);
				if ($urandom_range(1))
					send_byte(cmd);
				repeat ($urandom_range(0, (cmd == desp_pkg::CMD_CURSOR) ? 1 : 2))
					send_byte(plain_byte());
				send_byte(desp_pkg::ESC_BYTE);
			end else begin
				repeat ($urandom_range(1, 3)) begin
					if ($urandom_range(3) == 0)
						send_byte(desp_pkg::ESC_BYTE);
					else
						send_byte(byte_t'($urandom_range(255)));
				end
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 20;
		recv_idle_pct = 85;

		// Directed part. Extremes of a printed byte.
		send_byte(8'h00);
		send_byte(8'hFF);
		// Set cursor with extreme row and column.
		send_byte(desp_pkg::ESC_BYTE);
		send_byte(desp_pkg::CMD_CURSOR);
		send_byte(8'h00);
		send_byte(8'hFF);
		// A clear-highlight sequence interrupted by an escape, then a full set highlight.
		send_byte(desp_pkg::ESC_BYTE);
		send_byte(desp_pkg::CMD_CLR_HL);
		send_byte(8'h7F);
		send_byte(desp_pkg::ESC_BYTE);
		send_byte(desp_pkg::CMD_SET_HL);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h80);
		// Complete clear highlight.
		send_byte(desp_pkg::ESC_BYTE);
		send_byte(desp_pkg::CMD_CLR_HL);
		send_byte(8'h7F);
		send_byte(8'h01);
		send_byte(8'hFE);
		// Unknown command cut off by an escape, then an unknown command whose
		// following byte is printed.
		send_byte(desp_pkg::ESC_BYTE);
		send_byte(8'hFF);
		send_byte(desp_pkg::ESC_BYTE);
		send_byte(8'h00);
		send_byte(8'h41);
		wait_for_drain();

		// Random part in three stall phases; the sender waits for the pipeline to
		// empty between them.
		send_random_stream(PHASE_BYTES);
		wait_for_drain();

		send_idle_pct = 85;
		recv_idle_pct = 20;
		send_random_stream(PHASE_BYTES);
		wait_for_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_stream(PHASE_BYTES);
		wait_for_drain();

		// Run on a little so that a stray extra result is still caught.
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
